@@ design/rrts_pkg.sv @@
// Package for the round-robin thread scheduler: slot count, operation and
// action codes, controller-to-datapath command and status types, a helper function.
// Depends on nothing.
package rrts_pkg;

	// Number of thread slots. The slot field is three bits wide, so the table
	// holds at most eight slots.
	localparam int unsigned THREAD_SLOTS = 8;
	localparam int unsigned SLOT_W       = 3;
	localparam int unsigned TIME_W       = 32;
	localparam int unsigned OP_W         = 3;
	localparam int unsigned ACT_W        = 2;
	localparam int unsigned PROBE_CNT_W  = $clog2(THREAD_SLOTS + 1);

	// Slot count at the width of a zero-extended slot number, for range checks.
	localparam logic [SLOT_W:0] SLOT_LIMIT = (SLOT_W + 1)'(THREAD_SLOTS);

	// Operation codes.
	localparam logic [OP_W-1:0] OP_START   = 3'd0;
	localparam logic [OP_W-1:0] OP_TICK    = 3'd1;
	localparam logic [OP_W-1:0] OP_CREATE  = 3'd2;
	localparam logic [OP_W-1:0] OP_DELETE  = 3'd3;
	localparam logic [OP_W-1:0] OP_RESTART = 3'd4;
	localparam logic [OP_W-1:0] OP_BLOCK   = 3'd5;
	localparam logic [OP_W-1:0] OP_UNBLOCK = 3'd6;
	localparam logic [OP_W-1:0] OP_DELAY   = 3'd7;

	// Slot action codes.
	localparam logic [ACT_W-1:0] ACT_BLOCKED = 2'd0;
	localparam logic [ACT_W-1:0] ACT_RUNNING = 2'd1;
	localparam logic [ACT_W-1:0] ACT_DELETE  = 2'd2;
	localparam logic [ACT_W-1:0] ACT_RESTART = 2'd3;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load_in;     // capture the input transaction
		logic apply_op;    // apply the operation to the slot table
		logic accumulate;  // add elapsed time to the outgoing thread
		logic probe;       // examine one slot of the round-robin walk
		logic probe_last;  // this probe is the final one of the walk
		logic load_out;    // load the result register
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic pass_req;    // the operation calls for a scheduling pass
		logic probe_hit;   // the probed slot has been chosen
	} dp_status_t;

	// Next slot in round-robin order.
	function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] idx);
		logic [SLOT_W-1:0] nxt;
		if ({1'b0, idx} == SLOT_LIMIT - 1'b1) begin
			nxt = '0;
		end else begin
			nxt = idx + 1'b1;
		end
		return nxt;
	endfunction

endpackage

@@ design/rrts_ctrl.sv @@
// Controller state machine of the round-robin thread scheduler: input and
// output handshakes, sequencing of the operation, accounting and probe walk.
// Depends on rrts_pkg.
module rrts_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	output logic                 out_valid,
	input  logic                 out_stall,
	input  rrts_pkg::dp_status_t status,
	output rrts_pkg::dp_cmd_t    cmd
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_EXEC  = 3'd1;
	localparam logic [2:0] ST_ACC   = 3'd2;
	localparam logic [2:0] ST_PROBE = 3'd3;
	localparam logic [2:0] ST_DONE  = 3'd4;

	logic [2:0]                          state_q;
	logic [2:0]                          state_d;
	logic [rrts_pkg::PROBE_CNT_W-1:0]    probe_cnt_q;
	logic                                out_valid_q;
	logic                                in_fire;
	logic                                out_free;
	logic                                last_probe;

	assign in_stall   = (state_q != ST_IDLE);
	assign in_fire    = in_valid && !in_stall;
	assign out_valid  = out_valid_q;
	assign out_free   = !out_valid_q || !out_stall;
	assign last_probe = (probe_cnt_q == rrts_pkg::PROBE_CNT_W'(rrts_pkg::THREAD_SLOTS));

	// Next state and commands.
	always_comb begin
		state_d        = state_q;
		cmd            = '0;
		cmd.probe_last = last_probe;
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					cmd.load_in = 1'b1;
					state_d     = ST_EXEC;
				end
			end
			ST_EXEC: begin
				cmd.apply_op = 1'b1;
				state_d      = status.pass_req ? ST_ACC : ST_DONE;
			end
			ST_ACC: begin
				cmd.accumulate = 1'b1;
				state_d        = ST_PROBE;
			end
			ST_PROBE: begin
				cmd.probe = 1'b1;
				if (status.probe_hit || last_probe) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State register and probe counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			probe_cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_ACC) begin
				probe_cnt_q <= '0;
			end else if (state_q == ST_PROBE) begin
				probe_cnt_q <= probe_cnt_q + 1'b1;
			end
		end
	end

	// The result stays valid until its transaction completes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

@@ design/rrts_datapath.sv @@
// Datapath of the round-robin thread scheduler: the slot table, the running
// thread, time accounting and the result register. Depends on rrts_pkg.
module rrts_datapath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  rrts_pkg::dp_cmd_t                   cmd,
	output rrts_pkg::dp_status_t                status,
	input  logic [rrts_pkg::OP_W-1:0]           operation,
	input  logic [rrts_pkg::SLOT_W-1:0]         slot,
	input  logic [rrts_pkg::TIME_W-1:0]         now,
	input  logic [rrts_pkg::TIME_W-1:0]         delay_ms,
	input  logic                                user_lock,
	output logic [rrts_pkg::SLOT_W-1:0]         current_slot,
	output logic [rrts_pkg::SLOT_W-1:0]         created_slot,
	output logic                                create_full,
	output logic                                context_reset,
	output logic                                switched,
	output logic [rrts_pkg::TIME_W-1:0]         outgoing_run_time
);

	localparam int unsigned N = rrts_pkg::THREAD_SLOTS;
	localparam int unsigned SW = rrts_pkg::SLOT_W;
	localparam int unsigned TW = rrts_pkg::TIME_W;
	localparam int unsigned AW = rrts_pkg::ACT_W;

	// Captured input transaction.
	logic [rrts_pkg::OP_W-1:0] op_q;
	logic [SW-1:0]             slot_q;
	logic [TW-1:0]             now_q;
	logic [TW-1:0]             delay_q;
	logic                      lock_q;

	// Slot table and scheduler state.
	logic [N-1:0]  occupied_q;
	logic [AW-1:0] action_q [N];
	logic [TW-1:0] wake_q   [N];
	logic [TW-1:0] run_time_q [N];
	logic [SW-1:0] running_q;
	logic          started_q;
	logic [TW-1:0] last_tick_q;

	// Work registers.
	logic [TW-1:0] diff_q;
	logic [SW-1:0] probe_idx_q;

	// Result of the transaction in progress.
	logic [SW-1:0] created_q;
	logic          full_q;
	logic          ctx_q;
	logic          pass_q;
	logic [TW-1:0] outgoing_q;

	// Result register.
	logic [SW-1:0] res_current_q;
	logic [SW-1:0] res_created_q;
	logic          res_full_q;
	logic          res_ctx_q;
	logic          res_switched_q;
	logic [TW-1:0] res_outgoing_q;

	logic          pass_op;
	logic [SW-1:0] free_idx;
	logic          free_found;
	logic [SW-1:0] first_occ;
	logic [SW-1:0] target;
	logic          target_ok;
	logic          slot_ok;
	logic [AW-1:0] target_act;
	logic          probe_base;
	logic [AW-1:0] probe_act;
	logic          probe_hit;
	logic          probe_del;
	logic          probe_rst;
	logic [TW-1:0] acc_sum;

	// Operations that end in a scheduling pass.
	always_comb begin
		unique case (op_q) inside
			rrts_pkg::OP_TICK, rrts_pkg::OP_DELETE, rrts_pkg::OP_RESTART,
			rrts_pkg::OP_BLOCK, rrts_pkg::OP_DELAY: pass_op = 1'b1;
			default: pass_op = 1'b0;
		endcase
	end

	assign status.pass_req = pass_op && started_q && !lock_q;

	// First free and first occupied user slot, searched from slot 1.
	always_comb begin
		free_idx   = '0;
		free_found = 1'b0;
		first_occ  = '0;
		for (int i = N - 1; i >= 1; i--) begin
			if (!occupied_q[i]) begin
				free_idx   = SW'(i);
				free_found = 1'b1;
			end else begin
				first_occ = SW'(i);
			end
		end
	end

	// Target of delete, restart and block; slot 0 stands for the current thread.
	always_comb begin
		if (slot_q == '0) begin
			target = started_q ? running_q : '0;
		end else begin
			target = slot_q;
		end
		target_ok = (target != '0) && ({1'b0, target} < rrts_pkg::SLOT_LIMIT);
		slot_ok   = (slot_q != '0) && ({1'b0, slot_q} < rrts_pkg::SLOT_LIMIT);
		if (op_q == rrts_pkg::OP_DELETE) begin
			target_act = rrts_pkg::ACT_DELETE;
		end else if (op_q == rrts_pkg::OP_RESTART) begin
			target_act = rrts_pkg::ACT_RESTART;
		end else begin
			target_act = rrts_pkg::ACT_BLOCKED;
		end
	end

	// Evaluation of the slot under the probe.
	always_comb begin
		probe_act  = action_q[probe_idx_q];
		probe_base = (probe_idx_q != '0) && occupied_q[probe_idx_q]
			&& (now_q > wake_q[probe_idx_q]);
		probe_del  = probe_base && (probe_act == rrts_pkg::ACT_DELETE);
		probe_rst  = probe_base && (probe_act == rrts_pkg::ACT_RESTART);
		probe_hit  = probe_rst || (probe_base && (probe_act == rrts_pkg::ACT_RUNNING));
	end

	assign status.probe_hit = probe_hit;
	assign acc_sum          = run_time_q[running_q] + diff_q;

	// Input capture.
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			op_q    <= operation;
			slot_q  <= slot;
			now_q   <= now;
			delay_q <= delay_ms;
			lock_q  <= user_lock;
		end
	end

	// Slot table, running thread and per-transaction results.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occupied_q  <= '0;
			running_q   <= '0;
			started_q   <= 1'b0;
			last_tick_q <= '0;
			for (int i = 0; i < N; i++) begin
				action_q[i]   <= rrts_pkg::ACT_BLOCKED;
				wake_q[i]     <= '0;
				run_time_q[i] <= '0;
			end
		end else begin
			if (cmd.apply_op) begin
				unique case (op_q) inside
					rrts_pkg::OP_START: begin
						occupied_q[0] <= 1'b1;
						action_q[0]   <= rrts_pkg::ACT_RUNNING;
						run_time_q[0] <= '0;
						running_q     <= first_occ;
						started_q     <= 1'b1;
					end
					rrts_pkg::OP_TICK: begin
					end
					rrts_pkg::OP_CREATE: begin
						if (free_found) begin
							occupied_q[free_idx] <= 1'b1;
							action_q[free_idx]   <= rrts_pkg::ACT_RUNNING;
							run_time_q[free_idx] <= '0;
						end
					end
					rrts_pkg::OP_DELETE, rrts_pkg::OP_RESTART, rrts_pkg::OP_BLOCK: begin
						if (target_ok) begin
							action_q[target] <= target_act;
						end
					end
					rrts_pkg::OP_UNBLOCK: begin
						if (slot_ok) begin
							action_q[slot_q] <= rrts_pkg::ACT_RUNNING;
						end
					end
					rrts_pkg::OP_DELAY: begin
						if (started_q && running_q != '0) begin
							wake_q[running_q] <= now_q + delay_q;
						end
					end
					default: begin
					end
				endcase
			end
			// Charge the elapsed time to the outgoing thread.
			if (cmd.accumulate) begin
				run_time_q[running_q] <= acc_sum;
			end
			// One step of the round-robin walk.
			if (cmd.probe) begin
				if (probe_del) begin
					occupied_q[probe_idx_q] <= 1'b0;
				end
				if (probe_rst) begin
					action_q[probe_idx_q]   <= rrts_pkg::ACT_RUNNING;
					run_time_q[probe_idx_q] <= '0;
				end
				if (probe_hit) begin
					running_q   <= probe_idx_q;
					last_tick_q <= now_q;
				end else if (cmd.probe_last) begin
					running_q   <= '0;
					last_tick_q <= now_q;
				end
			end
		end
	end

	// Work registers and results of the transaction in progress.
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			created_q  <= '0;
			full_q     <= 1'b0;
			ctx_q      <= 1'b0;
			pass_q     <= 1'b0;
			outgoing_q <= '0;
		end
		if (cmd.apply_op) begin
			diff_q <= now_q - last_tick_q;
			pass_q <= status.pass_req;
			if (op_q == rrts_pkg::OP_CREATE) begin
				full_q    <= !free_found;
				created_q <= free_found ? free_idx : '0;
			end
		end
		if (cmd.accumulate) begin
			outgoing_q  <= acc_sum;
			probe_idx_q <= rrts_pkg::next_slot(running_q);
		end
		if (cmd.probe) begin
			probe_idx_q <= rrts_pkg::next_slot(probe_idx_q);
			if (probe_rst) begin
				ctx_q <= 1'b1;
			end
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			res_current_q  <= started_q ? running_q : '0;
			res_created_q  <= created_q;
			res_full_q     <= full_q;
			res_ctx_q      <= ctx_q;
			res_switched_q <= pass_q;
			res_outgoing_q <= outgoing_q;
		end
	end

	assign current_slot      = res_current_q;
	assign created_slot      = res_created_q;
	assign create_full       = res_full_q;
	assign context_reset     = res_ctx_q;
	assign switched          = res_switched_q;
	assign outgoing_run_time = res_outgoing_q;

endmodule

@@ design/round_robin_thread_scheduler.sv @@
// Round-robin thread scheduler. Each accepted transaction applies one
// operation (start, tick, create, delete, restart, block, unblock or delay)
// to a table of eight thread slots and returns one result transaction. A new
// transaction is accepted only while the scheduler is idle; the result sits
// in an output register, so the next transaction may be accepted while it
// waits. Operations that run no scheduling pass go through the idle, execute
// and done states. A scheduling pass adds the accounting state and k probes,
// where k (1 to 9) is the number of slots probed: the round-robin walk
// examines one slot per cycle. Tick, delete, restart, block and delay
// run a pass once the scheduler is started and the user lock is clear.
// Depends on rrts_pkg, rrts_ctrl and rrts_datapath.
module round_robin_thread_scheduler (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [rrts_pkg::OP_W-1:0]      operation,
	input  logic [rrts_pkg::SLOT_W-1:0]    slot,
	input  logic [rrts_pkg::TIME_W-1:0]    now,
	input  logic [rrts_pkg::TIME_W-1:0]    delay_ms,
	input  logic                           user_lock,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [rrts_pkg::SLOT_W-1:0]    current_slot,
	output logic [rrts_pkg::SLOT_W-1:0]    created_slot,
	output logic                           create_full,
	output logic                           context_reset,
	output logic                           switched,
	output logic [rrts_pkg::TIME_W-1:0]    outgoing_run_time
);

	rrts_pkg::dp_cmd_t    cmd;
	rrts_pkg::dp_status_t status;

	// Sequencing and handshakes.
	rrts_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd)
	);

	// Slot table and result.
	rrts_datapath u_datapath (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.status            (status),
		.operation         (operation),
		.slot              (slot),
		.now               (now),
		.delay_ms          (delay_ms),
		.user_lock         (user_lock),
		.current_slot      (current_slot),
		.created_slot      (created_slot),
		.create_full       (create_full),
		.context_reset     (context_reset),
		.switched          (switched),
		.outgoing_run_time (outgoing_run_time)
	);

endmodule
